// ===== rtl/cte_pkg.sv =====
// ============================================================================
// cte_pkg
// Shared types, constants and helper functions for the calendar to epoch
// seconds converter pipeline.
// ============================================================================
package cte_pkg;

  // Calendar constants.
  localparam int unsigned YEAR_EPOCH     = 1970;
  localparam int unsigned YEAR_CENTURY   = 1900;
  localparam int unsigned YEAR_TWO_DIGIT = 70;
  localparam int unsigned ZONE_LIMIT     = 1200;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned HOURS_PER_DAY  = 24;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned HOUR_LIMIT     = 24;
  localparam int unsigned MINSEC_LIMIT   = 60;
  localparam int unsigned DAY_LIMIT      = 31;
  localparam int unsigned MONTH_LAST     = 11;
  localparam int unsigned MONTH_FEB      = 1;
  // Leap days before 1970 counted by (year - 1) / 4.
  localparam int unsigned LEAP_BASE      = (YEAR_EPOCH - 1) / 4;
  // Largest year the repair stage can produce is 4096; centuries up to 4000.
  localparam int unsigned CENTURY_COUNT  = 41;

  // Reset value of the current year register.
  localparam logic [11:0] CUR_YEAR_RESET = 12'd2024;

  // Cycles from an accepted item to its result strobe.
  localparam int unsigned LATENCY = 6;

  // Month codes.
  typedef enum logic [3:0] {
    MON_JAN = 4'd0,  MON_FEB = 4'd1,  MON_MAR = 4'd2,  MON_APR = 4'd3,
    MON_MAY = 4'd4,  MON_JUN = 4'd5,  MON_JUL = 4'd6,  MON_AUG = 4'd7,
    MON_SEP = 4'd8,  MON_OCT = 4'd9,  MON_NOV = 4'd10, MON_DEC = 4'd11
  } cte_month_t;

  // Repaired fields leaving the first stage.
  typedef struct packed {
    logic [12:0]        yr;
    logic [3:0]         mon;
    logic [4:0]         day;
    logic [4:0]         hr;
    logic [5:0]         mi;
    logic [5:0]         se;
    logic signed [4:0]  zone_hr;
    logic signed [7:0]  zone_mi;
  } cte_fields_t;

  // Hour count and remaining terms leaving the day stages.
  typedef struct packed {
    logic signed [25:0] hour_count;
    logic signed [8:0]  min_adj;
    logic [5:0]         sec;
  } cte_hours_t;

  // Gregorian leap test for years up to 4096.
  function automatic logic cte_is_leap(input logic [12:0] yr);
    logic c100;
    logic c400;
    c100 = 1'b0;
    c400 = 1'b0;
    for (int k = 0; k < CENTURY_COUNT; k++) begin
      if (yr == 13'(k * 100)) begin
        c100 = 1'b1;
        if ((k & 3) == 0) begin
          c400 = 1'b1;
        end
      end
    end
    return (yr[1:0] == 2'b00) && (!c100 || c400);
  endfunction

  // Days in the common year before the first of the month.
  function automatic logic [8:0] cte_days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      MON_JAN: d = 9'd0;
      MON_FEB: d = 9'd31;
      MON_MAR: d = 9'd59;
      MON_APR: d = 9'd90;
      MON_MAY: d = 9'd120;
      MON_JUN: d = 9'd151;
      MON_JUL: d = 9'd181;
      MON_AUG: d = 9'd212;
      MON_SEP: d = 9'd243;
      MON_OCT: d = 9'd273;
      MON_NOV: d = 9'd304;
      MON_DEC: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/cte_repair.sv =====
// ============================================================================
// cte_repair
// First pipeline stage: replaces unusable fields by their defaults and
// splits the negated zone offset into hours and minutes.
// ============================================================================
module cte_repair (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [11:0]        cur_year,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month_index,
  input  logic [6:0]         in_day_of_month,
  input  logic [6:0]         in_hours,
  input  logic [6:0]         in_minutes,
  input  logic [6:0]         in_seconds,
  input  logic signed [14:0] in_zone_hhmm,
  output logic               out_valid,
  output cte_pkg::cte_fields_t out_fields
);

  logic                 valid_r;
  cte_pkg::cte_fields_t fields_r;
  cte_pkg::cte_fields_t fields_nxt;

  logic [12:0] cy_p1;
  logic [13:0] yr_sum;
  logic [15:0] zone_neg;
  logic [15:0] zone_mag;
  logic [10:0] mag;
  logic [23:0] quot_prod;
  logic [3:0]  quot;
  logic [6:0]  rem;
  logic        zone_west;

  // Field repair and zone split.
  always_comb begin
    fields_nxt = '0;
    cy_p1      = {1'b0, cur_year} + 13'd1;
    yr_sum     = in_year + 14'(cte_pkg::YEAR_CENTURY);

    // Year: values from 70 to 1969 get 1900 added, out of range takes the
    // current year.
    if ((in_year < 14'(cte_pkg::YEAR_EPOCH)) && (in_year >= 14'(cte_pkg::YEAR_TWO_DIGIT))) begin
      fields_nxt.yr = yr_sum[12:0];
    end else if ((in_year < 14'(cte_pkg::YEAR_TWO_DIGIT)) || (in_year > {1'b0, cy_p1})) begin
      fields_nxt.yr = {1'b0, cur_year};
    end else begin
      fields_nxt.yr = in_year[12:0];
    end

    fields_nxt.mon = (in_month_index > 4'(cte_pkg::MONTH_LAST)) ? 4'(cte_pkg::MON_JAN)
                                                                : in_month_index;
    fields_nxt.day = ((in_day_of_month < 7'd1) || (in_day_of_month > 7'(cte_pkg::DAY_LIMIT)))
                     ? 5'd1 : in_day_of_month[4:0];
    fields_nxt.hr  = (in_hours > 7'(cte_pkg::HOUR_LIMIT)) ? 5'd0 : in_hours[4:0];
    fields_nxt.mi  = (in_minutes > 7'(cte_pkg::MINSEC_LIMIT)) ? 6'd0 : in_minutes[5:0];
    fields_nxt.se  = (in_seconds > 7'(cte_pkg::MINSEC_LIMIT)) ? 6'd0 : in_seconds[5:0];

    // Zone: negate, drop if too large, then split by 100 with truncation.
    // The quotient uses a reciprocal multiply that is exact below 1201.
    zone_neg  = 16'd0 - {in_zone_hhmm[14], in_zone_hhmm};
    zone_west = zone_neg[15];
    zone_mag  = zone_west ? (16'd0 - zone_neg) : zone_neg;
    mag       = (zone_mag > 16'(cte_pkg::ZONE_LIMIT)) ? 11'd0 : zone_mag[10:0];
    quot_prod = 24'(mag) * 24'd5243;
    quot      = quot_prod[22:19];
    rem       = 7'(mag - (11'(quot) * 11'd100));

    fields_nxt.zone_hr = zone_west ? $signed(5'd0 - {1'b0, quot}) : $signed({1'b0, quot});
    fields_nxt.zone_mi = zone_west ? $signed(8'd0 - {1'b0, rem}) : $signed({1'b0, rem});
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    fields_r <= fields_nxt;
  end

  assign out_valid  = valid_r;
  assign out_fields = fields_r;

endmodule

// ===== rtl/cte_days.sv =====
// ============================================================================
// cte_days
// Second and third pipeline stages: counts days since 1970 in closed form
// and turns them into a signed hour count including the zone hours.
// ============================================================================
module cte_days (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cte_pkg::cte_fields_t in_fields,
  output logic                 out_valid,
  output cte_pkg::cte_hours_t  out_hours
);

  // Stage two registers.
  logic              valid2_r;
  logic [19:0]       dby_r;
  logic [19:0]       dby_nxt;
  logic [8:0]        dpart_r;
  logic [8:0]        dpart_nxt;
  logic signed [6:0] hsum_r;
  logic signed [6:0] hsum_nxt;
  logic signed [8:0] msum_r;
  logic signed [8:0] msum_nxt;
  logic [5:0]        sec2_r;

  // Stage three registers.
  logic                valid3_r;
  cte_pkg::cte_hours_t hours_r;
  cte_pkg::cte_hours_t hours_nxt;

  logic        leap;
  logic [8:0]  dbm;
  logic [11:0] yr_off;
  logic [12:0] yr_m1;
  logic [19:0] days;
  logic [25:0] hour_base;

  // Days before the year and before the day, plus the small hour and
  // minute sums.
  always_comb begin
    leap   = cte_pkg::cte_is_leap(in_fields.yr);
    dbm    = cte_pkg::cte_days_before_month(in_fields.mon);
    yr_off = 12'(in_fields.yr - 13'(cte_pkg::YEAR_EPOCH));
    yr_m1  = in_fields.yr - 13'd1;
    if (in_fields.yr > 13'(cte_pkg::YEAR_EPOCH)) begin
      dby_nxt = (20'(yr_off) * 20'(cte_pkg::DAYS_PER_YEAR)) + 20'(yr_m1[12:2])
                - 20'(cte_pkg::LEAP_BASE);
    end else begin
      dby_nxt = 20'd0;
    end
    dpart_nxt = 9'(in_fields.day - 5'd1) + dbm
                + 9'((leap && (in_fields.mon > 4'(cte_pkg::MONTH_FEB))) ? 1 : 0);
    hsum_nxt  = $signed({2'b00, in_fields.hr})
                + $signed({{2{in_fields.zone_hr[4]}}, in_fields.zone_hr});
    msum_nxt  = $signed({3'b000, in_fields.mi})
                + $signed({in_fields.zone_mi[7], in_fields.zone_mi});
  end

  // Total days and the hour count.
  always_comb begin
    days                 = dby_r + 20'(dpart_r);
    hour_base            = 26'(days) * 26'(cte_pkg::HOURS_PER_DAY);
    hours_nxt.hour_count = $signed(hour_base) + $signed({{19{hsum_r[6]}}, hsum_r});
    hours_nxt.min_adj    = msum_r;
    hours_nxt.sec        = sec2_r;
  end

  // Stage registers with their valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      valid2_r <= in_valid;
      valid3_r <= valid2_r;
    end
    dby_r   <= dby_nxt;
    dpart_r <= dpart_nxt;
    hsum_r  <= hsum_nxt;
    msum_r  <= msum_nxt;
    sec2_r  <= in_fields.se;
    hours_r <= hours_nxt;
  end

  assign out_valid = valid3_r;
  assign out_hours = hours_r;

endmodule

// ===== rtl/cte_scale.sv =====
// ============================================================================
// cte_scale
// Last three pipeline stages: hours to minutes, minutes to seconds, then
// clamping of the signed total into the unsigned 32-bit result.
// ============================================================================
module cte_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cte_pkg::cte_hours_t in_hours,
  output logic                out_valid,
  output logic [31:0]         out_seconds
);

  logic               valid4_r;
  logic signed [32:0] mins_r;
  logic signed [32:0] mins_nxt;
  logic [5:0]         sec4_r;

  logic               valid5_r;
  logic signed [37:0] total_r;
  logic signed [37:0] total_nxt;

  logic               valid6_r;
  logic [31:0]        result_r;
  logic [31:0]        result_nxt;

  // Minutes, seconds and the range clamp.
  always_comb begin
    mins_nxt  = ($signed({{7{in_hours.hour_count[25]}}, in_hours.hour_count})
                 * $signed(33'(cte_pkg::SECS_PER_MIN)))
                + $signed({{24{in_hours.min_adj[8]}}, in_hours.min_adj});
    total_nxt = ($signed({{5{mins_r[32]}}, mins_r}) * $signed(38'(cte_pkg::SECS_PER_MIN)))
                + $signed({32'd0, sec4_r});
    if (total_r[37]) begin
      result_nxt = 32'd0;
    end else if (|total_r[36:32]) begin
      result_nxt = '1;
    end else begin
      result_nxt = total_r[31:0];
    end
  end

  // Stage registers with their valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid4_r <= 1'b0;
      valid5_r <= 1'b0;
      valid6_r <= 1'b0;
    end else begin
      valid4_r <= in_valid;
      valid5_r <= valid4_r;
      valid6_r <= valid5_r;
    end
    mins_r   <= mins_nxt;
    sec4_r   <= in_hours.sec;
    total_r  <= total_nxt;
    result_r <= result_nxt;
  end

  assign out_valid   = valid6_r;
  assign out_seconds = result_r;

endmodule

// ===== rtl/calendar_to_epoch_seconds.sv =====
// ============================================================================
// calendar_to_epoch_seconds
// Converts a mail date given as numeric fields into seconds since 1970 UTC.
// ============================================================================
// The converter is a six-stage pipeline that takes one item in every clock
// cycle while busy is low. An item is accepted when start is high and busy
// is low; its result appears on out_epoch_seconds with out_valid high for
// one cycle, and results leave in the order items came in. The result is
// formed by the stage chain: field repair, day count, hour count, minutes,
// seconds and the range clamp, each ending in a register. busy is high only
// while reset is applied and in the first cycle after it. The receiver has no
// way to stall the pipeline and must take each result in its strobe cycle.
// current_year may be written through cfg_we and cfg_wdata while no item is
// in flight.
// ============================================================================
module calendar_to_epoch_seconds (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month_index,
  input  logic [6:0]         in_day_of_month,
  input  logic [6:0]         in_hours,
  input  logic [6:0]         in_minutes,
  input  logic [6:0]         in_seconds,
  input  logic signed [14:0] in_zone_hhmm,
  output logic               out_valid,
  output logic [31:0]        out_epoch_seconds,
  input  logic               cfg_we,
  input  logic [11:0]        cfg_wdata
);

  logic                 busy_r;
  logic [11:0]          cur_year_r;
  logic                 accept;
  logic                 s1_valid;
  cte_pkg::cte_fields_t s1_fields;
  logic                 s3_valid;
  cte_pkg::cte_hours_t  s3_hours;

  assign accept = start && !busy_r;

  // Busy flag and the current year register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      cur_year_r <= cte_pkg::CUR_YEAR_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        cur_year_r <= cfg_wdata;
      end
    end
  end

  assign busy = busy_r;

  cte_repair u_repair (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (accept),
    .cur_year        (cur_year_r),
    .in_year         (in_year),
    .in_month_index  (in_month_index),
    .in_day_of_month (in_day_of_month),
    .in_hours        (in_hours),
    .in_minutes      (in_minutes),
    .in_seconds      (in_seconds),
    .in_zone_hhmm    (in_zone_hhmm),
    .out_valid       (s1_valid),
    .out_fields      (s1_fields)
  );

  cte_days u_days (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_fields (s1_fields),
    .out_valid (s3_valid),
    .out_hours (s3_hours)
  );

  cte_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s3_valid),
    .in_hours    (s3_hours),
    .out_valid   (out_valid),
    .out_seconds (out_epoch_seconds)
  );

endmodule

// ===== rtl/cte_checker.sv =====
// ============================================================================
// cte_checker
// Port-level timing checks for the converter, bound to the top level.
// ============================================================================
module cte_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // Every accepted item yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(cte_pkg::LATENCY) out_valid)
    else $error("accepted item produced no result");

  // No result without an item accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, cte_pkg::LATENCY))
    else $error("result strobe without a matching item");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Outside reset the block always takes items.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind calendar_to_epoch_seconds cte_checker u_cte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ===== bench/calendar_to_epoch_seconds_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_tb
// Self-checking bench for the mail date converter. A short table of directed
// dates runs first, then bursts of random dates under several current-year
// settings. Every result is checked against a known row epoch or an in-bench date predictor.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_tb;

  // One date as it sits on the input ports.
  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         mon;
    logic [6:0]         day;
    logic [6:0]         hr;
    logic [6:0]         mi;
    logic [6:0]         se;
    logic signed [14:0] zone;
  } date_t;

  // A directed row; epoch is used only when known is set.
  typedef struct packed {
    date_t       stamp;
    logic        known;
    logic [31:0] epoch;
  } stim_row_t;

  // Month codes the block does not recognize.
  localparam logic [3:0] MON_UNUSED_LO = 4'd12;
  localparam logic [3:0] MON_UNUSED_HI = 4'd15;

  localparam int          DIRECTED_ROWS    = 20;
  localparam int          RANDOM_PER_PHASE = 105;
  localparam int          YEAR_PHASES      = 5;
  localparam int          QUIET_LIMIT      = 1000;
  localparam int          MAX_REPORTS      = 40;
  localparam logic [31:0] EPOCH_MAX        = 32'hFFFF_FFFF;

  // Current-year settings written between phases, extremes included.
  localparam logic [11:0] YEAR_SETTINGS [YEAR_PHASES] =
    '{12'd1970, 12'd2099, 12'd4095, 12'd0, 12'd2037};

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [13:0]        in_year;
  logic [3:0]         in_month_index;
  logic [6:0]         in_day_of_month;
  logic [6:0]         in_hours;
  logic [6:0]         in_minutes;
  logic [6:0]         in_seconds;
  logic signed [14:0] in_zone_hhmm;
  logic               out_valid;
  logic [31:0]        out_epoch_seconds;
  logic               cfg_we;
  logic [11:0]        cfg_wdata;

  // Side information that travels with the item on the ports.
  logic        row_known;
  logic [31:0] row_epoch;

  logic [11:0] year_setting;
  logic [11:0] year_model = cte_pkg::CUR_YEAR_RESET;
  logic [31:0] pending_epochs [$];
  int          errors = 0;
  int          quiet_cycles = 0;

  // Directed dates, checked under the reset year 2024.
  stim_row_t date_table [DIRECTED_ROWS] = '{
    // Epoch start, plain and with a forward zone that goes negative.
    '{'{14'd1970, cte_pkg::MON_JAN, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd0}, 1'b1, 32'd0},
    '{'{14'd1970, cte_pkg::MON_JAN, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd1200}, 1'b1, 32'd0},
    // 1969 is moved to 3869 and saturates.
    '{'{14'd1969, cte_pkg::MON_DEC, 7'd31, 7'd23, 7'd59, 7'd59, -15'sd1200}, 1'b1,
      EPOCH_MAX},
    '{'{14'd70, cte_pkg::MON_JAN, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd0}, 1'b1, 32'd0},
    '{'{14'd1999, cte_pkg::MON_DEC, 7'd31, 7'd23, 7'd59, 7'd59, 15'sd0}, 1'b1,
      32'd946684799},
    // Out-of-range fields, and fields at their limits.
    '{'{14'd0, MON_UNUSED_HI, 7'd0, 7'd127, 7'd127, 7'd127, 15'sd0}, 1'b0, 32'd0},
    '{'{14'd16383, MON_UNUSED_LO, 7'd127, 7'd25, 7'd61, 7'd61, 15'sd16383}, 1'b0, 32'd0},
    '{'{14'd69, cte_pkg::MON_FEB, 7'd29, 7'd24, 7'd60, 7'd60, 15'h4000}, 1'b0, 32'd0},
    // Upper year limit and the year just past it.
    '{'{14'd2025, cte_pkg::MON_DEC, 7'd31, 7'd23, 7'd59, 7'd59, -15'sd1200}, 1'b0, 32'd0},
    '{'{14'd2026, cte_pkg::MON_MAR, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd1201}, 1'b0, 32'd0},
    // Leap February: by four, by four hundred, and a plain century.
    '{'{14'd2024, cte_pkg::MON_MAR, 7'd1, 7'd0, 7'd0, 7'd0, -15'sd1201}, 1'b0, 32'd0},
    '{'{14'd2000, cte_pkg::MON_MAR, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd0}, 1'b0, 32'd0},
    '{'{14'd200, cte_pkg::MON_MAR, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd0}, 1'b0, 32'd0},
    // Zone remainders and truncation toward zero.
    '{'{14'd1970, cte_pkg::MON_JAN, 7'd32, 7'd0, 7'd0, 7'd0, -15'sd99}, 1'b0, 32'd0},
    '{'{14'd1970, cte_pkg::MON_JAN, 7'd1, 7'd0, 7'd0, 7'd0, 15'sd150}, 1'b0, 32'd0},
    '{'{14'd106, cte_pkg::MON_JUL, 7'd15, 7'd12, 7'd30, 7'd45, 15'sd530}, 1'b0, 32'd0},
    '{'{14'd1970, cte_pkg::MON_JAN, 7'd31, 7'd24, 7'd60, 7'd60, 15'sd1159}, 1'b0, 32'd0},
    '{'{14'd99, cte_pkg::MON_NOV, 7'd30, 7'd1, 7'd2, 7'd3, -15'sd1159}, 1'b0, 32'd0},
    '{'{14'd8191, cte_pkg::MON_AUG, 7'd64, 7'd64, 7'd32, 7'd16, -15'sd1}, 1'b0, 32'd0},
    '{'{14'd1971, cte_pkg::MON_FEB, 7'd28, 7'd8, 7'd0, 7'd0, 15'sd1}, 1'b0, 32'd0}
  };

  calendar_to_epoch_seconds dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_year           (in_year),
    .in_month_index    (in_month_index),
    .in_day_of_month   (in_day_of_month),
    .in_hours          (in_hours),
    .in_minutes        (in_minutes),
    .in_seconds        (in_seconds),
    .in_zone_hhmm      (in_zone_hhmm),
    .out_valid         (out_valid),
    .out_epoch_seconds (out_epoch_seconds),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Seconds since 1970 for one date, after the field repairs.
  function automatic logic [31:0] epoch_of_date(input date_t d, input logic [11:0] cy);
    int     month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    longint yr;
    longint day;
    longint hr;
    longint mi;
    longint se;
    longint zone;
    longint days;
    longint total;
    int     mon;
    bit     leap;
    yr   = d.year;
    mon  = d.mon;
    day  = d.day;
    hr   = d.hr;
    mi   = d.mi;
    se   = d.se;
    zone = d.zone;
    // Years from 70 to 1969 get 1900 added; unusable years become current.
    if (yr >= 70 && yr < 1970) begin
      yr = yr + 1900;
    end else if (yr < 70 || yr > longint'(cy) + 1) begin
      yr = cy;
    end
    // The offset is subtracted; a magnitude above twelve hours is dropped.
    zone = -zone;
    if (zone > 1200 || zone < -1200) begin
      zone = 0;
    end
    if (mon > 11) begin
      mon = 0;
    end
    if (day < 1 || day > 31) begin
      day = 1;
    end
    if (hr > 24) begin
      hr = 0;
    end
    if (mi > 60) begin
      mi = 0;
    end
    if (se > 60) begin
      se = 0;
    end
    // Only the date's own February follows the full Gregorian rule.
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    days = day - 1;
    for (int i = 0; i < mon; i++) begin
      days = days + month_days[i];
      if (i == 1 && leap) begin
        days = days + 1;
      end
    end
    if (yr > 1970) begin
      days = days + 365 * (yr - 1970) + ((yr - 1) / 4 - 1969 / 4);
    end
    total = se + 60 * (mi + (zone % 100) + 60 * (hr + (zone / 100) + 24 * days));
    if (total < 0) begin
      total = 0;
    end
    if (total > longint'(EPOCH_MAX)) begin
      total = EPOCH_MAX;
    end
    return total[31:0];
  endfunction

  // Random date: mostly plausible, some near the repair limits, some raw noise.
  function automatic date_t random_date(input logic [11:0] cy);
    date_t d;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      case ($urandom_range(0, 2))
        0: d.year = 14'($urandom_range(70, 99));
        1: d.year = 14'($urandom_range(70, 210));
        default: d.year = 14'($urandom_range(1970, int'(cy) + 1));
      endcase
      d.mon  = 4'($urandom_range(cte_pkg::MON_JAN, cte_pkg::MON_DEC));
      d.day  = 7'($urandom_range(1, 31));
      d.hr   = 7'($urandom_range(0, 24));
      d.mi   = 7'($urandom_range(0, 60));
      d.se   = 7'($urandom_range(0, 60));
      d.zone = 15'(int'($urandom_range(0, 2400)) - 1200);
    end else if (pick == 7) begin
      case ($urandom_range(0, 7))
        0: d.year = 14'd69;
        1: d.year = 14'd70;
        2: d.year = 14'd1969;
        3: d.year = 14'd1970;
        4: d.year = 14'(cy);
        5: d.year = 14'(cy) + 14'd1;
        6: d.year = 14'(cy) + 14'd2;
        default: d.year = 14'd16383;
      endcase
      case ($urandom_range(0, 3))
        0: d.mon = cte_pkg::MON_FEB;
        1: d.mon = cte_pkg::MON_MAR;
        2: d.mon = cte_pkg::MON_DEC;
        default: d.mon = MON_UNUSED_LO;
      endcase
      case ($urandom_range(0, 4))
        0: d.day = 7'd0;
        1: d.day = 7'd29;
        2: d.day = 7'd31;
        3: d.day = 7'd32;
        default: d.day = 7'd1;
      endcase
      d.hr = 7'($urandom_range(23, 25));
      d.mi = 7'($urandom_range(59, 61));
      d.se = 7'($urandom_range(59, 61));
      case ($urandom_range(0, 6))
        0: d.zone = 15'sd1200;
        1: d.zone = -15'sd1200;
        2: d.zone = 15'sd1201;
        3: d.zone = -15'sd1201;
        4: d.zone = 15'sd99;
        5: d.zone = -15'sd150;
        default: d.zone = 15'h4000;
      endcase
    end else begin
      d.year = 14'($urandom);
      d.mon  = 4'($urandom);
      d.day  = 7'($urandom);
      d.hr   = 7'($urandom);
      d.mi   = 7'($urandom);
      d.se   = 7'($urandom);
      d.zone = 15'($urandom);
    end
    return d;
  endfunction

  // Present one date and hold it until the block takes it.
  task automatic issue_date(input date_t d, input logic known, input logic [31:0] epoch);
    @(negedge clk);
    start           <= 1'b1;
    in_year         <= d.year;
    in_month_index  <= d.mon;
    in_day_of_month <= d.day;
    in_hours        <= d.hr;
    in_minutes      <= d.mi;
    in_seconds      <= d.se;
    in_zone_hhmm    <= d.zone;
    row_known       <= known;
    row_epoch       <= epoch;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Idle the sender for a number of cycles.
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stop sending and wait until every pending conversion has come back.
  task automatic drain_results();
    pause_sender(1);
    while (pending_epochs.size() != 0) begin
      @(posedge clk);
    end
    repeat (cte_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_current_year(input logic [11:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    year_setting = value;
  endtask

  // Random dates in bursts; some long bursts run with no gaps at all.
  task automatic run_random_dates(input int count);
    int burst_left;
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(30, 80);
        end else begin
          pause_sender($urandom_range(1, 12));
          burst_left = $urandom_range(1, 20);
        end
      end
      issue_date(random_date(year_setting), 1'b0, 32'd0);
      burst_left--;
    end
  endtask

  // Checks each result against the oldest pending epoch, then records new items.
  always @(posedge clk) begin : score
    date_t       taken;
    logic [31:0] want;
    if (!rst_n) begin
      year_model = cte_pkg::CUR_YEAR_RESET;
    end else begin
      if (out_valid) begin
        if (pending_epochs.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result with no item waiting, expected none, actual %0d",
                     $time, out_epoch_seconds);
          end
        end else begin
          want = pending_epochs.pop_front();
          if (out_epoch_seconds !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: epoch_seconds expected %0d, actual %0d",
                       $time, want, out_epoch_seconds);
            end
          end
        end
      end
      if (start && !busy) begin
        taken.year = in_year;
        taken.mon  = in_month_index;
        taken.day  = in_day_of_month;
        taken.hr   = in_hours;
        taken.mi   = in_minutes;
        taken.se   = in_seconds;
        taken.zone = in_zone_hhmm;
        pending_epochs.push_back(row_known ? row_epoch : epoch_of_date(taken, year_model));
      end
      if (cfg_we) begin
        year_model = cfg_wdata;
      end
    end
  end

  // Watchdog on cycles that neither take an item nor deliver a result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired, no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_year         = '0;
    in_month_index  = '0;
    in_day_of_month = '0;
    in_hours        = '0;
    in_minutes      = '0;
    in_seconds      = '0;
    in_zone_hhmm    = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    row_known       = 1'b0;
    row_epoch       = '0;
    year_setting    = cte_pkg::CUR_YEAR_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, then random dates, under the reset year.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      issue_date(date_table[r].stamp, date_table[r].known, date_table[r].epoch);
    end
    run_random_dates(RANDOM_PER_PHASE);

    // Each new year setting is written only once the pipeline is empty.
    for (int p = 0; p < YEAR_PHASES; p++) begin
      drain_results();
      write_current_year(YEAR_SETTINGS[p]);
      run_random_dates(RANDOM_PER_PHASE);
    end

    drain_results();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
